// ===== hw/rtl/sbda_pkg.sv =====
package sbda_pkg;

    localparam int CHUNK_W     = 16;
    localparam int STEP_W      = CHUNK_W + 4;
    localparam int RECIP_SHIFT = 23;
    localparam logic [STEP_W-1:0] RECIP = STEP_W'(838861);

    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_MINUS = 7'd45;
    localparam logic [3:0] RADIX      = 4'd10;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic div_en;
        logic store_en;
        logic load_minus;
        logic load_digit;
    } t_ctrl;

endpackage

// ===== hw/rtl/sbda_div10_step.sv =====
module sbda_div10_step
    import sbda_pkg::*;
(
    input  logic [3:0]         i_rem,
    input  logic [CHUNK_W-1:0] i_chunk,
    output logic [CHUNK_W-1:0] o_quot,
    output logic [3:0]         o_rem
);

    logic [STEP_W-1:0]   w_num;
    logic [2*STEP_W-1:0] w_prod;
    logic [STEP_W-1:0]   w_quot_ext;
    logic [STEP_W-1:0]   w_times_ten;
    logic [STEP_W-1:0]   w_rem_ext;

    assign w_num       = {i_rem, i_chunk};
    assign w_prod      = {{STEP_W{1'b0}}, w_num} * {{STEP_W{1'b0}}, RECIP};
    assign w_quot_ext  = STEP_W'(w_prod >> RECIP_SHIFT);
    assign w_times_ten = (w_quot_ext << 3) + (w_quot_ext << 1);
    assign w_rem_ext   = w_num - w_times_ten;
    assign o_quot      = w_quot_ext[CHUNK_W-1:0];
    assign o_rem       = w_rem_ext[3:0];

endmodule

// ===== hw/rtl/signed_binary_to_decimal_ascii.sv =====
// Converts one signed VALUE_BITS-wide integer per request into its decimal
// text, one ASCII character per output beat: a minus sign for negative values,
// then the digits most significant first without leading zeros, tlast on the
// final digit. A shared divide-by-ten step unit works through the magnitude
// 16 bits per cycle, one 16-bit chunk after another for each digit. A value is
// first accepted, then divided down digit by digit, then a minus sign is sent
// if it is negative, and then its digits go out one per beat, where the output
// may stall any beat. A new request is taken as soon as the last character has
// been registered for output. At most NUM_DIGITS low-order digits are kept.
module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int NUM_DIGITS = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [VALUE_BITS-1:0] value
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [6:0] out_char, [7] zero
    output logic [7:0]                           m_axis_tdata,
    output logic                                 m_axis_tlast
);

    localparam int NCHUNK = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int MAG_W  = NCHUNK * CHUNK_W;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int CNT_W  = $clog2(NUM_DIGITS + 1);
    localparam int IDX_W  = $clog2(NUM_DIGITS);

    t_state r_state, n_state;
    t_ctrl  w_ctrl;

    logic [MAG_W-1:0]   r_mag;
    logic [3:0]         r_rem;
    logic [CW-1:0]      r_chunk;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_neg;
    logic [3:0]         r_digits [NUM_DIGITS];
    logic               r_out_valid;
    logic [6:0]         r_out_char;
    logic               r_out_last;

    logic [VALUE_BITS-1:0] w_value;
    logic [VALUE_BITS-1:0] w_abs;
    logic [CHUNK_W-1:0]    w_quot;
    logic [3:0]            w_rem;
    logic [MAG_W-1:0]      w_mag_next;
    logic                  w_last_chunk;
    logic                  w_div_done;
    logic                  w_slot_free;
    logic [CNT_W-1:0]      w_cnt_dec;

    assign w_value      = s_axis_tdata[VALUE_BITS-1:0];
    assign w_abs        = w_value[VALUE_BITS-1] ? (~w_value + 1'b1) : w_value;
    assign w_last_chunk = (r_chunk == CW'(NCHUNK - 1));
    assign w_slot_free  = !r_out_valid || m_axis_tready;
    assign w_cnt_dec    = r_cnt - 1'b1;

    sbda_div10_step u_step (
        .i_rem   (r_rem),
        .i_chunk (r_mag[MAG_W-1 -: CHUNK_W]),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    generate
        if (NCHUNK > 1) begin : g_shift
            assign w_mag_next = {r_mag[MAG_W-CHUNK_W-1:0], w_quot};
        end else begin : g_single
            assign w_mag_next = w_quot;
        end
    endgenerate

    assign w_div_done = w_last_chunk &&
                        ((w_mag_next == '0) || (r_cnt == CNT_W'(NUM_DIGITS - 1)));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) n_state = r_neg ? S_SIGN : S_EMIT;
            end
            S_SIGN: begin
                if (w_slot_free) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot_free && (r_cnt == CNT_W'(1))) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ctrl = '0;
        unique case (r_state)
            S_IDLE: w_ctrl.in_ready = 1'b1;
            S_DIV: begin
                w_ctrl.div_en   = 1'b1;
                w_ctrl.store_en = w_last_chunk;
            end
            S_SIGN: w_ctrl.load_minus = w_slot_free;
            S_EMIT: w_ctrl.load_digit = w_slot_free;
            default: w_ctrl = '0;
        endcase
    end

    assign s_axis_tready = w_ctrl.in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chunk     <= '0;
            r_cnt       <= '0;
            r_neg       <= 1'b0;
            r_rem       <= '0;
            r_mag       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctrl.in_ready && s_axis_tvalid) begin
                r_neg   <= w_value[VALUE_BITS-1];
                r_mag   <= MAG_W'(w_abs);
                r_rem   <= '0;
                r_chunk <= '0;
                r_cnt   <= '0;
            end
            if (w_ctrl.div_en) begin
                r_mag <= w_mag_next;
                if (w_last_chunk) begin
                    r_rem   <= '0;
                    r_chunk <= '0;
                    r_cnt   <= r_cnt + 1'b1;
                end else begin
                    r_rem   <= w_rem;
                    r_chunk <= r_chunk + 1'b1;
                end
            end
            if (w_ctrl.load_digit) begin
                r_cnt <= w_cnt_dec;
            end
            if (w_ctrl.load_minus || w_ctrl.load_digit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.store_en) begin
            r_digits[r_cnt[IDX_W-1:0]] <= w_rem;
        end
        if (w_ctrl.load_minus) begin
            r_out_char <= CHAR_MINUS;
            r_out_last <= 1'b0;
        end else if (w_ctrl.load_digit) begin
            r_out_char <= CHAR_ZERO + {3'b000, r_digits[w_cnt_dec[IDX_W-1:0]]};
            r_out_last <= (r_cnt == CNT_W'(1));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_char};
    assign m_axis_tlast  = r_out_last;

endmodule
